>>> hw/rtl/pbe_pkg.sv
package pbe_pkg;

   localparam logic [31:0] SYNC_WORD     = 32'h7CD2_15D8;
   localparam logic [31:0] IDLE_WORD     = 32'h7A89_C197;
   localparam logic [31:0] PREAMBLE_WORD = 32'hAAAA_AAAA;
   localparam logic [10:0] BCH_POLY      = 11'h769;

   localparam logic [5:0] MAX_PREAMBLE_WORDS = 6'd32;
   localparam logic [4:0] BATCH_WORDS        = 5'd16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 21;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAPCODE  = 2'd0,
      CSR_FUNCTION = 2'd1,
      CSR_PREAMBLE = 2'd2,
      CSR_INVERT   = 2'd3
   } csr_index_type;

   // One queued command describes every word that one input item causes.
   typedef struct packed {
      logic        start;     // preamble, sync, leading idles and address word
      logic [5:0]  pre_cnt;   // saturated preamble length
      logic [3:0]  idle_cnt;  // idle words ahead of the address slot
      logic [19:0] addr_msg;  // address bits and function bits
      logic        cwa_vld;   // message word completed by this character
      logic [19:0] cwa_msg;
      logic        cwb_vld;   // padded or empty closing message word
      logic [19:0] cwb_msg;
      logic [4:0]  fill_cnt;  // idle words that close the batch
      logic        eob;       // the last word of this command ends the batch
   } cmd_type;

   // Check bits contributed by message bit pos: remainder of x^(pos+10) mod g(x).
   function automatic logic [9:0] bch_syndrome(input int unsigned pos);
      logic [30:0] rem;
      rem = 31'(1) << (pos + 10);
      for (int i = 30; i >= 10; i--) begin
         if (rem[i]) begin
            rem = rem ^ (31'(BCH_POLY) << (i - 10));
         end
      end
      return rem[9:0];
   endfunction

endpackage

>>> hw/rtl/pocsag_batch_encoder.sv
// Single-batch paging encoder with BCH(31,21) codewords and even parity.
// The req_ channel takes one message character per transaction: tdata is the
// byte (only bits 6..0 are sent), tlast marks the final character, tuser
// marks an item that carries no character. The rsp_ channel returns 32-bit
// transmit words, tlast on the final word an item causes and tuser on the
// final word that the closing item causes. The csr_ channel writes capcode,
// function bits, preamble length and invert mode; it is always ready and
// should only be written while the block is idle.
// The first item of a transmission yields preamble, sync, leading idle words
// and the address word; later characters usually yield at most one word.
// The front end classifies each item in the cycle it is accepted and queues
// at most one command; the back end turns a command into words, one per
// cycle while the receiver is ready. An item's first word passes the command
// queue, the back end's command register and the output register. Items of
// at most one word flow at one per cycle; the four-entry command queue
// absorbs longer bursts, and req_tready drops only when it is full.
// When the receiver stalls, the output register holds its word and the queue
// fills. Reset clears the control state and restores the register defaults.
module pocsag_batch_encoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] character
   input  logic                            req_tlast,
   input  logic                            req_tuser,   // [0] empty_message
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [31:0] word
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,   // [0] end_of_batch
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pbe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers. Capcode and function bits only matter when a
   // transmission opens; invert mode applies to each non-preamble word as it leaves.
   logic [20:0] capcode_ff, capcode_in;
   logic [1:0]  function_bits_ff, function_bits_in;
   logic [5:0]  preamble_words_ff, preamble_words_in;
   logic        invert_words_ff, invert_words_in;

   logic             q_full, q_empty, q_push, q_pop;
   pbe_pkg::cmd_type push_cmd, head_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      capcode_in        = capcode_ff;
      function_bits_in  = function_bits_ff;
      preamble_words_in = preamble_words_ff;
      invert_words_in   = invert_words_ff;
      if (csr_valid && csr_ready) begin
         case (pbe_pkg::csr_index_type'(csr_index))
            pbe_pkg::CSR_CAPCODE:  capcode_in        = csr_wdata[20:0];
            pbe_pkg::CSR_FUNCTION: function_bits_in  = csr_wdata[1:0];
            pbe_pkg::CSR_PREAMBLE: preamble_words_in = csr_wdata[5:0];
            pbe_pkg::CSR_INVERT:   invert_words_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capcode_ff        <= 21'd1422890;
         function_bits_ff  <= 2'd2;
         preamble_words_ff <= 6'd18;
         invert_words_ff   <= 1'b0;
      end else begin
         capcode_ff        <= capcode_in;
         function_bits_ff  <= function_bits_in;
         preamble_words_ff <= preamble_words_in;
         invert_words_ff   <= invert_words_in;
      end
   end

   // Front end: tracks packer and batch slot, emits at most one command per item.
   pbe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .character      (req_tdata),
      .last           (req_tlast),
      .empty_message  (req_tuser),
      .capcode        (capcode_ff),
      .function_bits  (function_bits_ff),
      .preamble_words (preamble_words_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (push_cmd)
   );

   pbe_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   // Back end: walks each command phase by phase and encodes the codewords.
   pbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .invert     (invert_words_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> hw/rtl/pbe_bch_enc.sv
module pbe_bch_enc (
   input  logic [20:0] msg,
   input  logic        invert,
   output logic [31:0] word
);

   logic [9:0]  chk;
   logic [30:0] body;
   logic [31:0] plain;

   always_comb begin
      chk = '0;
      for (int i = 0; i < 21; i++) begin
         if (msg[i]) begin
            chk = chk ^ pbe_pkg::bch_syndrome(i);
         end
      end
      body  = {msg, chk};
      plain = {body, ^body};
      word  = invert ? ~plain : plain;
   end

endmodule

>>> hw/rtl/pbe_front.sv
module pbe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        character,
   input  logic              last,
   input  logic              empty_message,
   input  logic [20:0]       capcode,
   input  logic [1:0]        function_bits,
   input  logic [5:0]        preamble_words,
   input  logic              q_full,
   output logic              q_push,
   output pbe_pkg::cmd_type  q_cmd
);

   logic        started_ff, started_in;
   logic [19:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [4:0]  bidx_ff, bidx_in;

   logic [6:0]  rev;
   logic [26:0] combined;
   logic [4:0]  tot;
   logic [2:0]  sh;
   logic        done_a;
   logic [19:0] acc_n;
   logic [4:0]  cnt_n;
   logic [4:0]  bidx0, bidx1, bidx2;
   logic        cwb_want;
   logic        has_words;
   logic        accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         rev[6-i] = character[i];
      end
      // Characters enter least significant bit first, so the first bit lands highest.
      combined = {acc_ff, rev};
      tot      = cnt_ff + 5'd7;
      sh       = '0;
      done_a   = 1'b0;
      acc_n    = acc_ff;
      cnt_n    = cnt_ff;
      q_cmd    = '0;

      if (!empty_message) begin
         if (tot >= 5'd20) begin
            sh     = 3'(tot - 5'd20);
            done_a = 1'b1;
            acc_n  = combined[19:0] & ~(20'hFFFFF << sh);
            cnt_n  = {2'b00, sh};
         end else begin
            acc_n = combined[19:0];
            cnt_n = tot;
         end
      end
      q_cmd.cwa_msg = 20'(combined >> sh);

      q_cmd.start    = !started_ff;
      q_cmd.pre_cnt  = (preamble_words > pbe_pkg::MAX_PREAMBLE_WORDS) ?
                       pbe_pkg::MAX_PREAMBLE_WORDS : preamble_words;
      q_cmd.idle_cnt = {capcode[2:0], 1'b0};
      q_cmd.addr_msg = {capcode[20:3], function_bits};

      bidx0 = started_ff ? bidx_ff : ({1'b0, capcode[2:0], 1'b0} + 5'd1);
      q_cmd.cwa_vld = done_a && (bidx0 < pbe_pkg::BATCH_WORDS);
      bidx1 = bidx0 + {4'd0, q_cmd.cwa_vld};

      cwb_want      = last && ((cnt_n != 5'd0) || empty_message);
      q_cmd.cwb_vld = cwb_want && (bidx1 < pbe_pkg::BATCH_WORDS);
      q_cmd.cwb_msg = (cnt_n != 5'd0) ? (acc_n << (5'd20 - cnt_n)) : 20'd0;
      bidx2 = bidx1 + {4'd0, q_cmd.cwb_vld};

      q_cmd.fill_cnt = last ? (pbe_pkg::BATCH_WORDS - bidx2) : 5'd0;
      q_cmd.eob      = last;

      has_words = q_cmd.start || q_cmd.cwa_vld || q_cmd.cwb_vld ||
                  (q_cmd.fill_cnt != 5'd0);
      q_push    = accept && has_words;

      started_in = started_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      bidx_in    = bidx_ff;
      if (accept) begin
         if (last) begin
            started_in = 1'b0;
            acc_in     = '0;
            cnt_in     = '0;
            bidx_in    = '0;
         end else begin
            started_in = 1'b1;
            acc_in     = acc_n;
            cnt_in     = cnt_n;
            bidx_in    = bidx1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         acc_ff     <= '0;
         cnt_ff     <= '0;
         bidx_ff    <= '0;
      end else begin
         started_ff <= started_in;
         acc_ff     <= acc_in;
         cnt_ff     <= cnt_in;
         bidx_ff    <= bidx_in;
      end
   end

endmodule

>>> hw/rtl/pbe_cmd_queue.sv
module pbe_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pbe_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output pbe_pkg::cmd_type  head_cmd,
   output logic              empty
);

   pbe_pkg::cmd_type mem_ff [pbe_pkg::QUEUE_DEPTH];

   logic [pbe_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pbe_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pbe_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign full     = (count_ff == (pbe_pkg::QUEUE_AW+1)'(pbe_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("command queue written while full");
`endif

`ifndef ASSERT_OFF
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("command queue read while empty");
`endif

endmodule

>>> hw/rtl/pbe_back.sv
module pbe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  pbe_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   input  logic              invert,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   typedef enum logic [2:0] {
      PH_PRE  = 3'd0,
      PH_SYNC = 3'd1,
      PH_IDLE = 3'd2,
      PH_ADDR = 3'd3,
      PH_CWA  = 3'd4,
      PH_CWB  = 3'd5,
      PH_FILL = 3'd6
   } phase_type;

   typedef struct packed {
      logic      found;
      phase_type phase;
   } pick_type;

   function automatic logic phase_has(input pbe_pkg::cmd_type c, input phase_type p);
      logic r;
      case (p)
         PH_PRE:  r = c.start && (c.pre_cnt != '0);
         PH_SYNC: r = c.start;
         PH_IDLE: r = c.start && (c.idle_cnt != '0);
         PH_ADDR: r = c.start;
         PH_CWA:  r = c.cwa_vld;
         PH_CWB:  r = c.cwb_vld;
         PH_FILL: r = (c.fill_cnt != '0);
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // First phase at or after from that has at least one word to send.
   function automatic pick_type pick_from(input pbe_pkg::cmd_type c, input int unsigned from);
      pick_type r;
      r = '0;
      for (int p = int'(PH_FILL); p >= int'(PH_PRE); p--) begin
         if ((p >= from) && phase_has(c, phase_type'(3'(p)))) begin
            r.found = 1'b1;
            r.phase = phase_type'(3'(p));
         end
      end
      return r;
   endfunction

   function automatic logic [5:0] phase_len(input pbe_pkg::cmd_type c, input phase_type p);
      logic [5:0] r;
      case (p)
         PH_PRE:  r = c.pre_cnt;
         PH_IDLE: r = {2'b00, c.idle_cnt};
         PH_FILL: r = {1'b0, c.fill_cnt};
         default: r = 6'd1;
      endcase
      return r;
   endfunction

   pbe_pkg::cmd_type cmd_ff, cmd_in;
   logic             have_ff, have_in;
   phase_type        phase_ff, phase_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             vld_ff, vld_in;
   logic [31:0]      data_ff, data_in;
   logic             last_ff, last_in;
   logic             eob_ff, eob_in;

   pick_type    nxt, head_first;
   logic        advance;
   logic        final_word;
   logic [20:0] enc_msg;
   logic [31:0] enc_word;
   logic [31:0] word;

   pbe_bch_enc u_bch (
      .msg    (enc_msg),
      .invert (invert),
      .word   (enc_word)
   );

   always_comb begin
      case (phase_ff)
         PH_ADDR: enc_msg = {1'b0, cmd_ff.addr_msg};
         PH_CWA:  enc_msg = {1'b1, cmd_ff.cwa_msg};
         default: enc_msg = {1'b1, cmd_ff.cwb_msg};
      endcase
      case (phase_ff)
         PH_PRE:           word = pbe_pkg::PREAMBLE_WORD;
         PH_SYNC:          word = invert ? ~pbe_pkg::SYNC_WORD : pbe_pkg::SYNC_WORD;
         PH_IDLE, PH_FILL: word = invert ? ~pbe_pkg::IDLE_WORD : pbe_pkg::IDLE_WORD;
         default:          word = enc_word;
      endcase

      advance    = !vld_ff || rsp_tready;
      nxt        = pick_from(cmd_ff, 32'(phase_ff) + 1);
      head_first = pick_from(q_cmd, 0);
      final_word = (cnt_ff == 6'd1) && !nxt.found;
      q_pop      = advance && !q_empty && (!have_ff || final_word);

      cmd_in   = cmd_ff;
      have_in  = have_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      vld_in   = vld_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      eob_in   = eob_ff;

      if (advance) begin
         vld_in = have_ff;
         if (have_ff) begin
            data_in = word;
            last_in = final_word;
            eob_in  = final_word && cmd_ff.eob;
            if (cnt_ff != 6'd1) begin
               cnt_in = cnt_ff - 6'd1;
            end else if (nxt.found) begin
               phase_in = nxt.phase;
               cnt_in   = phase_len(cmd_ff, nxt.phase);
            end else begin
               have_in = 1'b0;
            end
         end
         if (q_pop) begin
            cmd_in   = q_cmd;
            have_in  = 1'b1;
            phase_in = head_first.phase;
            cnt_in   = phase_len(q_cmd, head_first.phase);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff  <= 1'b0;
         vld_ff   <= 1'b0;
         phase_ff <= PH_PRE;
         cnt_ff   <= 6'd1;
      end else begin
         have_ff  <= have_in;
         vld_ff   <= vld_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff  <= cmd_in;
      data_ff <= data_in;
      last_ff <= last_in;
      eob_ff  <= eob_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = eob_ff;

`ifndef ASSERT_OFF
   a_eob_ends_run: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && eob_ff) |-> last_ff)
      else $error("end of batch flagged on a word that does not end its run");
`endif

`ifndef ASSERT_OFF
   a_header_needs_start: assert property (@(posedge clock) disable iff (reset)
      (have_ff && (phase_ff == PH_PRE || phase_ff == PH_SYNC ||
                   phase_ff == PH_IDLE || phase_ff == PH_ADDR)) |-> cmd_ff.start)
      else $error("header phase reached by a command that opens no transmission");
`endif

endmodule

>>> sim/pocsag_batch_encoder_tb.sv
module pocsag_batch_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles to wait after the last expected word before the block counts as
   // idle. An item can cause no word at all, so an empty store of expected
   // words alone does not prove that the back end has finished.
   localparam int DRAIN_CYCLES   = 16;
   // Length of the long receiver hold-off that fills the command queue.
   localparam int HOLD_CYCLES    = 300;
   // Cycles without any transaction before the run is declared hung. This is
   // several times the longest quiet stretch of a correct run, which is the
   // receiver hold-off.
   localparam int WATCHDOG_LIMIT = 3000;
   // Number of character transactions the whole run aims for.
   localparam int ITEM_TARGET    = 190;
   localparam int SCRIPT_LEN     = 32;
   // Items offered back to back while the receiver holds off.
   localparam int PRESSURE_ITEMS = 20;

   // Short names for the register indexes used in the directed table.
   localparam pbe_pkg::csr_index_type REG_CAP = pbe_pkg::CSR_CAPCODE;
   localparam pbe_pkg::csr_index_type REG_FUN = pbe_pkg::CSR_FUNCTION;
   localparam pbe_pkg::csr_index_type REG_PRE = pbe_pkg::CSR_PREAMBLE;
   localparam pbe_pkg::csr_index_type REG_INV = pbe_pkg::CSR_INVERT;

   typedef enum logic {
      ROW_CSR,
      ROW_ITEM
   } row_kind_type;

   // One directed step: either a register write or one character
   // transaction. Where the outcome is plain to see, the number of words and
   // the first word are typed in and checked against the predictor as well.
   typedef struct packed {
      row_kind_type           kind;
      pbe_pkg::csr_index_type idx;
      logic [20:0]            wdata;
      logic [7:0]             ch;
      logic                   fin;
      logic                   none;
      logic                   typed;
      logic [6:0]             typed_count;
      logic [31:0]            typed_first;
   } script_row_type;

   typedef struct {
      logic [31:0] word;
      logic        last_of_run;
      logic        end_of_batch;
   } tx_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = 8'd0;
   logic                            req_tlast = 1'b0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [31:0]                     rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tuser;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   pbe_pkg::csr_index_type          csr_index = pbe_pkg::CSR_CAPCODE;
   logic [pbe_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Register copies as the block should hold them.
   logic [20:0] cfg_capcode;
   logic [1:0]  cfg_function;
   logic [5:0]  cfg_preamble;
   logic        cfg_invert;

   // Encoder state: whether a transmission is open, the pending message
   // bits, how many of them there are and the next batch slot.
   logic        enc_open;
   logic [19:0] enc_bits;
   int          enc_nbits;
   int          enc_slot;

   // Words that the block still owes, oldest first.
   tx_word_type words_due[$];
   tx_word_type due_word;

   script_row_type script_rows [SCRIPT_LEN];

   int  mismatches = 0;
   int  items_sent = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   bit  hold_request = 1'b0;
   bit  idle_on = 1'b1;

   pocsag_batch_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endfunction

   // Builds a 32-bit codeword from 21 information bits: the BCH(31,21)
   // remainder goes below the information bits and an even-parity bit
   // closes the word.
   function automatic logic [31:0] bch_word(input logic [20:0] info);
      logic [30:0] rem;
      logic [31:0] w;
      int          b;
      rem = {info, 10'd0};
      for (b = 30; b >= 10; b--) begin
         if (rem[b]) begin
            rem = rem ^ ({20'd0, pbe_pkg::BCH_POLY} << (b - 10));
         end
      end
      w = {info, rem[9:0], 1'b0};
      w[0] = ^w;
      return w;
   endfunction

   function automatic void push_word(input logic [31:0] w);
      tx_word_type t;
      t.word = w;
      t.last_of_run = 1'b0;
      t.end_of_batch = 1'b0;
      words_due.insert(words_due.size(), t);
   endfunction

   // A word that occupies a batch slot. Slots past the end of the single
   // batch are silently dropped; all but preamble words follow invert mode.
   function automatic void slot_word(input logic [31:0] w);
      if (enc_slot < pbe_pkg::BATCH_WORDS) begin
         push_word(cfg_invert ? ~w : w);
         enc_slot++;
      end
   endfunction

   // Works out every word that one accepted character transaction causes,
   // appends them to the expected store and returns how many there are.
   function automatic int encode_item(input logic [7:0] ch, input logic fin,
                                      input logic none);
      int         n0;
      int         k;
      logic [5:0] pre;
      n0 = words_due.size();
      if (!enc_open) begin
         // Opening a transmission: preamble, sync, idles up to the frame
         // of the capcode, then the address word.
         pre = (cfg_preamble > pbe_pkg::MAX_PREAMBLE_WORDS) ?
               pbe_pkg::MAX_PREAMBLE_WORDS : cfg_preamble;
         for (k = 0; k < pre; k++) begin
            push_word(pbe_pkg::PREAMBLE_WORD);
         end
         push_word(cfg_invert ? ~pbe_pkg::SYNC_WORD : pbe_pkg::SYNC_WORD);
         enc_slot = 0;
         while (enc_slot < 2 * cfg_capcode[2:0]) begin
            slot_word(pbe_pkg::IDLE_WORD);
         end
         slot_word(bch_word({1'b0, cfg_capcode[20:3], cfg_function}));
         enc_bits = '0;
         enc_nbits = 0;
         enc_open = 1'b1;
      end
      if (!none) begin
         // Seven character bits, least significant first, shifted in at
         // the bottom of the pending message bits.
         for (k = 0; k < 7; k++) begin
            enc_bits = {enc_bits[18:0], ch[k]};
            enc_nbits++;
            if (enc_nbits == 20) begin
               slot_word(bch_word({1'b1, enc_bits}));
               enc_bits = '0;
               enc_nbits = 0;
            end
         end
      end
      if (fin) begin
         if (enc_nbits > 0) begin
            slot_word(bch_word({1'b1, enc_bits << (20 - enc_nbits)}));
         end else if (none) begin
            slot_word(bch_word({1'b1, 20'd0}));
         end
         while (enc_slot < pbe_pkg::BATCH_WORDS) begin
            slot_word(pbe_pkg::IDLE_WORD);
         end
         if (words_due.size() > n0) begin
            words_due[$].end_of_batch = 1'b1;
         end
         enc_open = 1'b0;
         enc_bits = '0;
         enc_nbits = 0;
         enc_slot = 0;
      end
      if (words_due.size() > n0) begin
         words_due[$].last_of_run = 1'b1;
      end
      return words_due.size() - n0;
   endfunction

   // Gap length: mostly none, sometimes short, rarely long; none if !idle_on.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Offers one character and waits for its transaction. tvalid stays high
   // afterwards so that the next item can follow back to back.
   task automatic send_item(input logic [7:0] ch, input logic fin, input logic none,
                            output int n_words);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= fin;
      req_tuser <= none;
      do @(posedge clock); while (!req_tready);
      n_words = encode_item(ch, fin, none);
      items_sent++;
   endtask

   task automatic pause_sender();
      int g;
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   // Stops offering items and waits until every expected word has come and
   // the back end has had time to finish anything that causes no word.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input pbe_pkg::csr_index_type idx,
                            input logic [pbe_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pbe_pkg::CSR_CAPCODE:  cfg_capcode = data[20:0];
         pbe_pkg::CSR_FUNCTION: cfg_function = data[1:0];
         pbe_pkg::CSR_PREAMBLE: cfg_preamble = data[5:0];
         pbe_pkg::CSR_INVERT:   cfg_invert = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random message. Most are well formed: a run of characters whose
   // final one carries tlast. Some close with an empty marker instead, some
   // are empty outright, some carry stray empty items in the middle, and a
   // few fill a codeword exactly or run past the end of the batch.
   task automatic send_message();
      int   n_chars;
      int   r;
      int   k;
      int   n;
      logic closing_empty;
      logic noisy;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         n_chars = 0;
      end else if (r < 70) begin
         n_chars = $urandom_range(1, 6);
      end else if (r < 85) begin
         n_chars = $urandom_range(7, 14);
      end else if (r < 95) begin
         n_chars = 20;
      end else begin
         n_chars = $urandom_range(21, 40);
      end
      closing_empty = (n_chars == 0) || ($urandom_range(0, 4) == 0);
      noisy = ($urandom_range(0, 3) == 0);
      for (k = 0; k < n_chars; k++) begin
         if (noisy && $urandom_range(0, 5) == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1, n);
            pause_sender();
         end
         send_item(8'($urandom), (k == n_chars - 1) && !closing_empty, 1'b0, n);
         pause_sender();
      end
      if (closing_empty) begin
         send_item(8'($urandom), 1'b1, 1'b1, n);
         pause_sender();
      end
   endtask

   // Receiver: tready changes at the falling edge. A hold-off request from
   // the stimulus keeps it low for a long stretch, counted here.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = gap_len();
         end
      end
   end

   // Every accepted word is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (words_due.size() == 0) begin
            note_failure($sformatf("word %08h arrived with nothing expected", rsp_tdata));
         end else begin
            due_word = words_due.pop_front();
            if (rsp_tdata !== due_word.word) begin
               note_failure($sformatf("word: expected %08h, got %08h",
                                      due_word.word, rsp_tdata));
            end
            if (rsp_tlast !== due_word.last_of_run) begin
               note_failure($sformatf("last_of_run on %08h: expected %b, got %b",
                                      due_word.word, due_word.last_of_run, rsp_tlast));
            end
            if (rsp_tuser !== due_word.end_of_batch) begin
               note_failure($sformatf("end_of_batch on %08h: expected %b, got %b",
                                      due_word.word, due_word.end_of_batch, rsp_tuser));
            end
         end
      end
   end

   // Watchdog: any transaction on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("pocsag_batch_encoder_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int             i;
      int             n;
      int             phase;
      logic           pending_items;
      script_row_type row;

      // Directed part. It opens on the reset defaults, then covers an empty
      // message in invert mode, the longest item (saturated preamble, last
      // frame and a padded word), a batch that overflows so that the last
      // item yields nothing, empty items inside a message and as its closing
      // marker with bits pending, and a preamble exactly at its maximum.
      script_rows = '{
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h41, 1'b0, 1'b0, 1'b1, 7'd24, 32'hAAAAAAAA},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'hFF, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h80, 1'b1, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_PRE, 21'd0,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_CAP, 21'd0,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_FUN, 21'd0,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_INV, 21'd1,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'hFF, 1'b1, 1'b1, 1'b1, 7'd17, 32'h832DEA27},
         '{ROW_CSR,  REG_PRE, 21'd40,     8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_CAP, 21'h1FFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_FUN, 21'd3,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_INV, 21'd0,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h7F, 1'b1, 1'b0, 1'b1, 7'd49, 32'hAAAAAAAA},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h55, 1'b0, 1'b0, 1'b1, 7'd48, 32'hAAAAAAAA},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h2A, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h7F, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h01, 1'b1, 1'b0, 1'b1, 7'd0,  32'h0},
         '{ROW_CSR,  REG_PRE, 21'd63,     8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_CAP, 21'd8,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_FUN, 21'd1,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_INV, 21'd1,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h00, 1'b0, 1'b1, 1'b1, 7'd34, 32'hAAAAAAAA},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h33, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'hC3, 1'b0, 1'b1, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h4C, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h00, 1'b1, 1'b1, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_PRE, 21'd32,     8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_CAP, 21'h155555, 8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_FUN, 21'd2,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_CSR,  REG_INV, 21'd0,      8'h00, 1'b0, 1'b0, 1'b0, 7'd0,  32'h0},
         '{ROW_ITEM, REG_CAP, 21'd0,      8'h2A, 1'b1, 1'b0, 1'b0, 7'd0,  32'h0}
      };

      // The register copies start from the block's reset defaults.
      cfg_capcode = 21'd1422890;
      cfg_function = 2'd2;
      cfg_preamble = 6'd18;
      cfg_invert = 1'b0;
      enc_open = 1'b0;
      enc_bits = '0;
      enc_nbits = 0;
      enc_slot = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pending_items = 1'b0;
      for (i = 0; i < SCRIPT_LEN; i++) begin
         row = script_rows[i];
         if (row.kind == ROW_CSR) begin
            if (pending_items) begin
               wait_drained();
               pending_items = 1'b0;
            end
            write_reg(row.idx, row.wdata);
         end else begin
            send_item(row.ch, row.fin, row.none, n);
            pending_items = 1'b1;
            if (row.typed && (n != row.typed_count
                || (n > 0 && words_due[words_due.size() - n].word !== row.typed_first))) begin
               note_failure($sformatf("step %0d: expected %0d words from %08h, predicted %0d",
                                      i, row.typed_count, row.typed_first, n));
            end
            pause_sender();
         end
      end

      // Back pressure: the receiver holds off for a long stretch while a
      // message is offered without gaps. The message completes enough
      // codewords to fill the command queue, so the block has to drop
      // req_tready. Then the sender waits for everything.
      wait_drained();
      idle_on = 1'b0;
      hold_request = 1'b1;
      for (i = 0; i < PRESSURE_ITEMS; i++) begin
         send_item(8'($urandom), i == PRESSURE_ITEMS - 1, 1'b0, n);
      end
      wait_drained();

      // Random phases. Each one reprograms all registers while the block is
      // idle, alternating in-range values with raw 21-bit data that the
      // block has to truncate, and every few phases runs without idling.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         case ($urandom_range(0, 3))
            0:       write_reg(pbe_pkg::CSR_CAPCODE, 21'd0);
            1:       write_reg(pbe_pkg::CSR_CAPCODE, 21'h1FFFFF);
            default: write_reg(pbe_pkg::CSR_CAPCODE, 21'($urandom));
         endcase
         if (phase % 2 == 1) begin
            write_reg(pbe_pkg::CSR_FUNCTION, 21'($urandom));
            write_reg(pbe_pkg::CSR_PREAMBLE, 21'($urandom));
            write_reg(pbe_pkg::CSR_INVERT, 21'($urandom));
         end else begin
            write_reg(pbe_pkg::CSR_FUNCTION, 21'($urandom_range(0, 3)));
            case ($urandom_range(0, 4))
               0:       write_reg(pbe_pkg::CSR_PREAMBLE, 21'd0);
               1:       write_reg(pbe_pkg::CSR_PREAMBLE, 21'd32);
               2:       write_reg(pbe_pkg::CSR_PREAMBLE, 21'd63);
               default: write_reg(pbe_pkg::CSR_PREAMBLE, 21'($urandom_range(0, 40)));
            endcase
            write_reg(pbe_pkg::CSR_INVERT, 21'($urandom_range(0, 1)));
         end
         idle_on = (phase % 4 != 2);
         repeat (4) send_message();
         phase++;
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("pocsag_batch_encoder_tb OK");
      end else begin
         $display("pocsag_batch_encoder_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/pbe_pkg.sv
hw/rtl/pbe_bch_enc.sv
hw/rtl/pbe_front.sv
hw/rtl/pbe_cmd_queue.sv
hw/rtl/pbe_back.sv
hw/rtl/pocsag_batch_encoder.sv
sim/pocsag_batch_encoder_tb.sv
